// ===== src/lppe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lppe_pkg;

    // Field widths
    localparam int COL_W   = 11;
    localparam int ROW_W   = 11;
    localparam int FH_W    = 16;
    localparam int X_W     = 16;
    localparam int Y_W     = 26;
    localparam int Z_W     = 19;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 22;
    localparam int BASE_W  = 21;
    localparam int FRAME_W = 16;

    localparam logic [FH_W-1:0] FH_RESET = 16'd512;

    // Column store
    localparam int MAX_COLUMNS = 2048;
    localparam int COL_AW      = $clog2(MAX_COLUMNS);
    localparam int COL_EXT_W   = COL_W + 2;
    localparam int EPOCH_W     = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Calibration
    localparam int CALIB_FRAMES = 3;
    localparam int MEAN_SH      = 8;
    localparam int DVD_W        = SUM_W + MEAN_SH;
    localparam int DIV_CNT_W    = $clog2(DVD_W + 1);
    localparam int SCALE_SH     = 22;
    localparam int SCALE_W      = SCALE_SH + 1;
    localparam int SCALE_RECIP  = ((1 << SCALE_SH) + CALIB_FRAMES - 1) / CALIB_FRAMES;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // x = column * 118 / 5 = column * 23 + (column * 3) / 5
    localparam int X_SCALE_NUM = 118;
    localparam int X_SCALE_DEN = 5;
    localparam int X_MUL_INT   = X_SCALE_NUM / X_SCALE_DEN;
    localparam int X_MUL_FRAC  = X_SCALE_NUM % X_SCALE_DEN;
    localparam int X_FRAC_W    = COL_W + 2;
    localparam int X_RECIP_SH  = 15;
    localparam int X_RECIP     = ((1 << X_RECIP_SH) + X_SCALE_DEN - 1) / X_SCALE_DEN;
    localparam int X_PROD_W    = X_RECIP_SH + X_FRAC_W;

    // y = frame * 11264 / 15, kept as quotient and remainder
    localparam int Y_NUM    = 11264;
    localparam int Y_DEN    = 15;
    localparam int Y_STEP_Q = Y_NUM / Y_DEN;
    localparam int Y_STEP_R = Y_NUM % Y_DEN;
    localparam int YR_W     = $clog2(Y_DEN);

    // Signed working width for threshold and depth
    localparam int TH_W = 24;

    // Queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              eof;
        logic              col_ok;
        logic [COL_AW-1:0] idx;
        logic [ROW_W-1:0]  row;
        logic [X_W-1:0]    x;
    } t_cmd;

    function automatic logic [COL_AW-1:0] col_index(input logic [COL_W-1:0] c);
        logic [COL_EXT_W-1:0] ext;
        ext = {2'b00, c};
        return ext[COL_AW-1:0];
    endfunction

    function automatic logic col_in_range(input logic [COL_W-1:0] c);
        return {2'b00, c} < COL_EXT_W'(MAX_COLUMNS);
    endfunction

endpackage

`default_nettype wire

// ===== src/lppe_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lppe_in_if import lppe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             lit;

    modport source (output valid, output kind, output column, output row, output lit,
                    input ready);
    modport sink   (input valid, input kind, input column, input row, input lit,
                    output ready);
endinterface

interface lppe_out_if import lppe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [X_W-1:0]        point_x;
    logic [Y_W-1:0]        point_y;
    logic signed [Z_W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

`default_nettype wire

// ===== src/lppe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppe_front import lppe_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lppe_in_if.sink    i_in,
    input  wire logic  i_hold,
    input  wire logic  i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic                r_s1_valid;
    logic                r_s1_eof;
    logic                r_s1_lit;
    logic [COL_W-1:0]    r_s1_col;
    logic [ROW_W-1:0]    r_s1_row;
    logic [X_W-1:0]      r_s1_c_int;
    logic [X_FRAC_W-1:0] r_s1_c_frac;

    logic                s1_keep;
    logic                s1_adv;
    logic                accept;
    logic [X_PROD_W-1:0] frac_prod;
    logic [X_FRAC_W-1:0] frac_q;

    // unlit pixels change nothing and are dropped here
    assign s1_keep    = r_s1_eof || r_s1_lit;
    assign s1_adv     = r_s1_valid && (!s1_keep || !i_full);
    assign i_in.ready = !i_hold && (!r_s1_valid || s1_adv);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_eof    <= i_in.kind;
            r_s1_lit    <= i_in.lit;
            r_s1_col    <= i_in.column;
            r_s1_row    <= i_in.row;
            r_s1_c_int  <= X_W'(i_in.column) * X_W'(X_MUL_INT);
            r_s1_c_frac <= X_FRAC_W'(i_in.column) * X_FRAC_W'(X_MUL_FRAC);
        end
    end

    // (column*3)/5 by reciprocal, exact over the whole column range
    assign frac_prod = X_PROD_W'(r_s1_c_frac) * X_PROD_W'(X_RECIP);
    assign frac_q    = frac_prod[X_RECIP_SH +: X_FRAC_W];

    assign o_push       = r_s1_valid && s1_keep && !i_full;
    assign o_cmd.eof    = r_s1_eof;
    assign o_cmd.col_ok = col_in_range(r_s1_col);
    assign o_cmd.idx    = col_index(r_s1_col);
    assign o_cmd.row    = r_s1_row;
    assign o_cmd.x      = r_s1_c_int + X_W'(frac_q);

endmodule

`default_nettype wire

// ===== src/lppe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppe_fifo import lppe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/lppe_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle; only the low quotient bits are kept
module lppe_div import lppe_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DVD_W-1:0]  i_dividend,
    input  wire logic [CNT_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [BASE_W-1:0]      o_quotient
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DVD_W-1:0]     r_dvd;
    logic [CNT_W-1:0]     r_dsr;
    logic [CNT_W-1:0]     r_rem;
    logic [BASE_W-1:0]    r_quo;

    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic                 ge;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_quo <= {r_quo[BASE_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== src/lppe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppe_back import lppe_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire t_cmd            i_cmd,
    output logic                 o_pop,
    input  wire logic [FH_W-1:0] i_fh,
    output logic                 o_clearing,
    lppe_out_if.source           o_out
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ACC   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    localparam int PROD_W = BASE_W + SCALE_W;

    logic [2:0]          r_state;
    logic [COL_AW-1:0]   r_clr_addr;
    logic [EPOCH_W-1:0]  r_epoch;
    logic                r_calib;
    logic [1:0]          r_seen;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [BASE_W-1:0]   r_base;
    logic [BASE_W-1:0]   r_mean;
    logic [PROD_W-1:0]   r_scale_prod;
    logic [FRAME_W-1:0]  r_frame;
    logic [Y_W-1:0]      r_yq;
    logic [YR_W-1:0]     r_yr;

    // pixel stage: column tag lookup in flight
    logic                r_p_valid;
    logic [COL_AW-1:0]   r_p_idx;
    logic [X_W-1:0]      r_p_x;
    logic [Z_W-1:0]      r_p_z;
    logic                r_p_pass;
    logic                r_p_byp;
    logic [EPOCH_W-1:0]  r_rd_tag;

    logic                r_o_valid;
    logic [X_W-1:0]      r_o_x;
    logic [Y_W-1:0]      r_o_y;
    logic [Z_W-1:0]      r_o_z;

    // column tags: entry is taken in this frame when it equals the epoch
    logic [EPOCH_W-1:0]  r_tag_mem [MAX_COLUMNS];

    logic                run;
    logic                out_free;
    logic                p_res;
    logic                p_adv;
    logic                p_free;
    logic                wr_p;
    logic                pop;
    logic                p_load;
    logic                eof_do;
    logic                cal_pix;
    logic                div_start;
    logic                div_done;
    logic [BASE_W-1:0]   div_quo;
    logic                mem_we;
    logic [COL_AW-1:0]   mem_wa;
    logic [EPOCH_W-1:0]  mem_wd;
    logic                n_byp;

    logic signed [TH_W-1:0] base_s;
    logic signed [TH_W-1:0] rq8_s;
    logic signed [TH_W-1:0] thr_s;
    logic signed [TH_W-1:0] diff_s;
    logic signed [TH_W-1:0] diff_adj;
    logic signed [TH_W-1:0] half_s;
    logic                   n_pass;

    logic [SUM_W:0]      sum_ext;
    logic [BASE_W-1:0]   n_base;
    logic [1:0]          n_seen;
    logic [YR_W:0]       yr_ext;

    assign run      = (r_state == ST_RUN);
    assign out_free = !r_o_valid || o_out.ready;
    assign p_res    = r_p_pass && !(r_p_byp || (r_rd_tag == r_epoch));
    assign p_adv    = r_p_valid && (!p_res || out_free);
    assign p_free   = !r_p_valid || p_adv;
    assign wr_p     = p_adv && p_res;

    always_comb begin
        pop     = 1'b0;
        p_load  = 1'b0;
        eof_do  = 1'b0;
        cal_pix = 1'b0;
        if (run && i_cmd_valid) begin
            priority if (i_cmd.eof) begin
                // frame end waits for the pixel stage to drain
                if (r_calib || !r_p_valid) begin
                    pop    = 1'b1;
                    eof_do = 1'b1;
                end
            end else if (r_calib) begin
                pop     = 1'b1;
                cal_pix = 1'b1;
            end else if (!i_cmd.col_ok) begin
                pop = 1'b1;
            end else if (p_free) begin
                pop    = 1'b1;
                p_load = 1'b1;
            end else begin
                // pixel stage busy: request waits at the queue head
                pop = 1'b0;
            end
        end
    end

    assign o_pop      = pop;
    assign o_clearing = (r_state == ST_CLEAR);

    // height filter and depth for the request at the queue head
    assign base_s   = $signed({{(TH_W-BASE_W){1'b0}}, r_base});
    assign rq8_s    = $signed({{(TH_W-ROW_W-8){1'b0}}, i_cmd.row, 8'd0});
    assign thr_s    = base_s - $signed({{(TH_W-FH_W-1){1'b0}}, i_fh, 1'b0});
    assign n_pass   = (rq8_s >= thr_s);
    assign diff_s   = base_s - rq8_s;
    assign diff_adj = diff_s + $signed({{(TH_W-1){1'b0}}, diff_s[TH_W-1]});
    assign half_s   = diff_adj >>> 1;

    // write just made at the same column is not yet seen by the read
    assign n_byp = wr_p && (r_p_idx == i_cmd.idx);

    assign mem_we = wr_p || (r_state == ST_CLEAR);
    assign mem_wa = (r_state == ST_CLEAR) ? r_clr_addr : r_p_idx;
    assign mem_wd = (r_state == ST_CLEAR) ? '0 : r_epoch;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tag_mem[mem_wa] <= mem_wd;
        end
        if (p_load) begin
            r_rd_tag <= r_tag_mem[i_cmd.idx];
        end
    end

    assign sum_ext   = {1'b0, r_sum} + (SUM_W+1)'(i_cmd.row);
    assign n_base    = r_base + r_mean;
    assign n_seen    = r_seen + 2'd1;
    assign yr_ext    = {1'b0, r_yr} + (YR_W+1)'(Y_STEP_R);
    assign div_start = eof_do && r_calib && (r_cnt != '0);

    lppe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum, {MEAN_SH{1'b0}}}),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
            r_calib    <= 1'b1;
            r_seen     <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_base     <= '0;
            r_frame    <= '0;
            r_yq       <= '0;
            r_yr       <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + COL_AW'(1);
                    if (r_clr_addr == COL_AW'(MAX_COLUMNS - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (cal_pix) begin
                        r_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                        if (r_cnt != CNT_MAX) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                    if (eof_do) begin
                        if (r_calib) begin
                            if (r_cnt == '0) begin
                                r_state <= ST_ACC;
                            end else begin
                                r_state <= ST_DIV;
                            end
                        end else begin
                            // next frame: advance y by 11264/15 in quotient/remainder form
                            if (r_frame == '1) begin
                                r_frame <= '0;
                                r_yq    <= '0;
                                r_yr    <= '0;
                            end else begin
                                r_frame <= r_frame + FRAME_W'(1);
                                if (yr_ext >= (YR_W+1)'(Y_DEN)) begin
                                    r_yr <= YR_W'(yr_ext - (YR_W+1)'(Y_DEN));
                                    r_yq <= r_yq + Y_W'(Y_STEP_Q + 1);
                                end else begin
                                    r_yr <= yr_ext[YR_W-1:0];
                                    r_yq <= r_yq + Y_W'(Y_STEP_Q);
                                end
                            end
                            // new epoch clears all columns; on wrap sweep the tags
                            if (r_epoch == EPOCH_LAST) begin
                                r_epoch <= EPOCH_FIRST;
                                r_state <= ST_CLEAR;
                            end else begin
                                r_epoch <= r_epoch + EPOCH_W'(1);
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_base <= n_base;
                    r_seen <= n_seen;
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    if (n_seen >= 2'(CALIB_FRAMES)) begin
                        r_state <= ST_SCALE;
                    end else begin
                        r_state <= ST_RUN;
                    end
                end
                ST_SCALE: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_base  <= r_scale_prod[SCALE_SH +: BASE_W];
                    r_calib <= 1'b0;
                    r_frame <= '0;
                    r_yq    <= '0;
                    r_yr    <= '0;
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && eof_do && r_calib && r_cnt == '0) begin
            r_mean <= '0;
        end else if (r_state == ST_DIV && div_done) begin
            r_mean <= div_quo;
        end
        if (r_state == ST_SCALE) begin
            r_scale_prod <= PROD_W'(r_base) * PROD_W'(SCALE_RECIP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_load) begin
                r_p_valid <= 1'b1;
            end else if (p_adv) begin
                r_p_valid <= 1'b0;
            end
            if (wr_p) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_load) begin
            r_p_idx  <= i_cmd.idx;
            r_p_x    <= i_cmd.x;
            r_p_z    <= half_s[Z_W-1:0];
            r_p_pass <= n_pass;
            r_p_byp  <= n_byp;
        end
        if (wr_p) begin
            r_o_x <= r_p_x;
            r_o_y <= r_yq;
            r_o_z <= r_p_z;
        end
    end

    assign o_out.valid   = r_o_valid;
    assign o_out.point_x = r_o_x;
    assign o_out.point_y = r_o_y;
    assign o_out.point_z = $signed(r_o_z);

endmodule

`default_nettype wire

// ===== src/laser_profile_point_extract_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Laser-line profile point extractor.
// i_in takes one request per pixel (kind 0) or frame end (kind 1) in raster order;
// o_out gives one 3-D point per topmost lit, in-filter pixel of each column.
// First three frames calibrate the baseline (mean lit row), no points come out;
// the host then replays the video from frame 0 and points follow.
// i_cfg_we/i_cfg_wdata load filter_height_q8 (reset 512); write only when idle.
// Throughput: one pixel per cycle unless o_out stalls or frame-end work is pending;
// column tags are read, then checked in the next cycle, with a back-to-back bypass.
// Points pass the input register, the command queue and the pixel stage to o_out.
// A calibration frame end holds the back end through the 40-step mean divider
// (when a pixel was lit) and accumulate; the last also scales (divide by three).
// An extraction frame end waits for the one pixel in flight to drain.
// Reset: tag RAM sweep over all MAX_COLUMNS (2048) entries with i_in.ready low; the
// same sweep repeats after every 255 extraction frames when the epoch wraps.
// Receiver stall: the output register holds its point, the pixel stage and the
// 4-entry command queue fill, then i_in.ready drops.
module laser_profile_point_extract_top import lppe_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [FH_W-1:0] i_cfg_wdata,
    lppe_in_if.sink              i_in,
    lppe_out_if.source           o_out
);

    logic [FH_W-1:0] r_fh;

    logic            push;
    logic            full;
    logic            pop;
    logic            q_valid;
    logic            clearing;
    t_cmd            front_cmd;
    t_cmd            q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh <= FH_RESET;
        end else if (i_cfg_we) begin
            r_fh <= i_cfg_wdata;
        end
    end

    // front: input register, drop of unlit pixels, x scaling
    lppe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_hold  (clearing),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // short queue lets the front keep taking pixels across frame-end work
    lppe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // back: calibration, column tags, point generation
    lppe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .i_fh        (r_fh),
        .o_clearing  (clearing),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== src/lppe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppe_checker import lppe_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire logic [X_W-1:0]        i_point_x,
    input wire logic [Y_W-1:0]        i_point_y,
    input wire logic signed [Z_W-1:0] i_point_z
);

    localparam int X_MAX = ((2 ** COL_W - 1) * X_SCALE_NUM) / X_SCALE_DEN;

    // tag sweep after reset: no request taken
    a_no_accept_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("input ready during post-reset tag sweep");

    a_no_point_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("point valid right after reset");

    a_x_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_point_x <= X_W'(X_MAX)))
        else $error("point_x beyond scaled column range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("point dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_point_x) && $stable(i_point_y) && $stable(i_point_z))
        else $error("point changed while stalled");

endmodule

bind laser_profile_point_extract_top lppe_checker u_lppe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_point_x   (o_out.point_x),
    .i_point_y   (o_out.point_y),
    .i_point_z   (o_out.point_z)
);

`default_nettype wire
